// File: rtl/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and block-word builder for the HOTP code checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DIGEST_W   = 160;
  localparam int unsigned CODE_OUT_W = 20;
  localparam int unsigned ROUNDS     = 80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] IPAD_WORD = 32'h36363636;
  localparam logic [31:0] OPAD_WORD = 32'h5C5C5C5C;
  localparam logic [31:0] PAD_ONE   = 32'h80000000;
  localparam logic [31:0] LEN_INNER = 32'd576;
  localparam logic [31:0] LEN_OUTER = 32'd672;

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_MID  = 2'd1;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd2;

  localparam logic [1:0] BLK_IPAD  = 2'd0;
  localparam logic [1:0] BLK_IMSG  = 2'd1;
  localparam logic [1:0] BLK_OPAD  = 2'd2;
  localparam logic [1:0] BLK_OMSG  = 2'd3;

  typedef struct packed {
    logic iv;
    logic start;
  } core_ctl_t;

  function automatic logic [31:0] blk_word(input logic [1:0]   blk,
                                           input logic [3:0]   idx,
                                           input logic [159:0] key,
                                           input logic [63:0]  ctr,
                                           input logic [159:0] inner);
    logic [31:0] kw;
    logic [31:0] dw;
    logic [31:0] r;
    kw = (idx < 4'd5) ? key[DIGEST_W - 1 - 32 * idx -: 32] : 32'h0;
    dw = (idx < 4'd5) ? inner[DIGEST_W - 1 - 32 * idx -: 32] : 32'h0;
    r  = 32'h0;
    unique case (blk)
      BLK_IPAD: r = kw ^ IPAD_WORD;
      BLK_OPAD: r = kw ^ OPAD_WORD;
      BLK_IMSG: begin
        if (idx == 4'd0) r = ctr[63:32];
        else if (idx == 4'd1) r = ctr[31:0];
        else if (idx == 4'd2) r = PAD_ONE;
        else if (idx == 4'd15) r = LEN_INNER;
      end
      BLK_OMSG: begin
        if (idx < 4'd5) r = dw;
        else if (idx == 4'd5) r = PAD_ONE;
        else if (idx == 4'd15) r = LEN_OUTER;
      end
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hcc_ram.sv
// ----------------------------------------------------------------------------
// hcc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/hcc_sha1_core.sv
// ----------------------------------------------------------------------------
// hcc_sha1_core
// SHA-1 compression, one round per cycle, block words read from the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_sha1_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hcc_pkg::core_ctl_t  ctl_i,
  input  wire logic [31:0]         rdata_i,
  output logic      [3:0]          raddr_o,
  output logic                     done_o,
  output logic      [159:0]        digest_o
);

  logic [4:0][31:0]  h_q;
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;
  logic [15:0][31:0] win_q;
  logic [6:0]        rnd_q;
  logic              busy_q, fin_q, done_q;
  logic [31:0]       w, f, k, t, x;

  always_comb begin
    x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    w = (rnd_q < 7'd16) ? rdata_i : {x[30:0], x[31]};
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = hcc_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = hcc_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = hcc_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = hcc_pkg::K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
  end

  assign raddr_o  = busy_q ? 4'(rnd_q + 7'd1) : 4'd0;
  assign done_o   = done_q;
  assign digest_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= 7'd0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'(hcc_pkg::ROUNDS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.iv) begin
      h_q <= {hcc_pkg::IV4, hcc_pkg::IV3, hcc_pkg::IV2, hcc_pkg::IV1, hcc_pkg::IV0};
    end else if (fin_q) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
    if (ctl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (busy_q) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      win_q <= {w, win_q[15:1]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/hcc_mod.sv
// ----------------------------------------------------------------------------
// hcc_mod
// Remainder by the constant modulus: reciprocal multiply, back-multiply and
// subtract, then one correcting subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_mod #(
  parameter int unsigned MODULUS = 1000000,
  parameter int unsigned CODE_W  = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [30:0]       value_i,
  output logic                   done_o,
  output logic      [CODE_W-1:0] rem_o
);

  localparam int unsigned MOD_W = $clog2(MODULUS);
  localparam int unsigned SHIFT = MOD_W + 30;
  localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(MODULUS));
  localparam logic [31:0] MOD32 = 32'(MODULUS);

  logic [30:0] val_q;
  logic [62:0] prod_q;
  logic [31:0] rem_q;
  logic [2:0]  stg_q;
  logic        done_q;
  logic [31:0] quo, quo_m;

  assign quo    = 32'(prod_q >> SHIFT);
  assign quo_m  = quo * MOD32;
  assign done_o = done_q;
  assign rem_o  = rem_q[CODE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      stg_q  <= {stg_q[1:0], start_i};
      done_q <= stg_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (stg_q[0]) begin
      prod_q <= 63'(val_q) * 63'(RECIP);
    end
    if (stg_q[1]) begin
      rem_q <= {1'b0, val_q} - quo_m;
    end else if (stg_q[2] && (rem_q >= MOD32)) begin
      rem_q <= rem_q - MOD32;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hotp_code_check.sv
// ----------------------------------------------------------------------------
// hotp_code_check
// HOTP check: HMAC-SHA-1 of the counter, dynamic truncation, reduce, compare.
// ----------------------------------------------------------------------------
//  channel | ports                                       | handshake
//  request | counter_i, candidate_code_i                 | in_valid_i / in_stall_o
//  result  | valid_res_o, computed_code_o                | out_valid_o / out_stall_i
//  config  | cfg_index_i, cfg_data_i                     | cfg_valid_i / cfg_ready_o
//
//  Each request runs four SHA-1 compressions; for each, the 16 block words are
//  written to the block RAM through its write port, then 80 rounds run and the
//  digest is added into the chaining state. Remainder and compare follow.
//  One request is worked at a time.
//  Reset clears the key registers and all control state.
//  A stalled result waits in the output register; a new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hotp_code_check #(
  parameter int unsigned CODE_MODULUS = 1000000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] counter_i,
  input  wire logic [19:0] candidate_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic      [19:0] computed_code_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int unsigned CODE_W = $clog2(CODE_MODULUS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [63:0]  key_low_q, key_mid_q;
  logic [31:0]  key_high_q;
  logic [63:0]  ctr_q;
  logic [19:0]  cand_q;
  logic [159:0] inner_q;
  logic [1:0]   blk_q;
  logic [3:0]   idx_q;
  logic         out_valid_q, res_q;
  logic [CODE_W-1:0] code_q;

  hcc_pkg::core_ctl_t ctl;
  logic         in_acc, core_done, mod_done, out_free;
  logic [3:0]   raddr;
  logic [31:0]  rdata, wdata;
  logic [159:0] digest;
  logic [7:0]   sh;
  logic [31:0]  tword;
  logic [CODE_W-1:0] rem;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign wdata = hcc_pkg::blk_word(blk_q, idx_q, {key_low_q, key_mid_q, key_high_q},
                                   ctr_q, inner_q);

  assign ctl.iv    = in_acc || (core_done && blk_q == hcc_pkg::BLK_IMSG);
  assign ctl.start = (state_q == ST_LOAD) && (idx_q == 4'd15);

  assign sh    = 8'd128 - {1'b0, digest[3:0], 3'b000};
  assign tword = 32'(digest >> sh);

  hcc_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_LOAD),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hcc_sha1_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rdata_i  (rdata),
    .raddr_o  (raddr),
    .done_o   (core_done),
    .digest_o (digest)
  );

  hcc_mod #(.MODULUS(CODE_MODULUS), .CODE_W(CODE_W)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_done && blk_q == hcc_pkg::BLK_OMSG),
    .value_i (tword[30:0]),
    .done_o  (mod_done),
    .rem_o   (rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_LOAD;
      ST_LOAD: if (idx_q == 4'd15) state_d = ST_RUN;
      ST_RUN: begin
        if (core_done) state_d = (blk_q == hcc_pkg::BLK_OMSG) ? ST_MOD : ST_LOAD;
      end
      ST_MOD:  if (mod_done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_low_q   <= 64'h0;
      key_mid_q   <= 64'h0;
      key_high_q  <= 32'h0;
      out_valid_q <= 1'b0;
      blk_q       <= hcc_pkg::BLK_IPAD;
      idx_q       <= 4'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          hcc_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
          hcc_pkg::CFG_KEY_MID:  key_mid_q  <= cfg_data_i;
          hcc_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        blk_q <= hcc_pkg::BLK_IPAD;
        idx_q <= 4'd0;
      end else if (state_q == ST_LOAD) begin
        idx_q <= idx_q + 4'd1;
      end else if (state_q == ST_RUN && core_done) begin
        blk_q <= blk_q + 2'd1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctr_q  <= counter_i;
      cand_q <= candidate_code_i;
    end
    if (core_done && blk_q == hcc_pkg::BLK_IMSG) begin
      inner_q <= digest;
    end
    if (mod_done) begin
      code_q <= rem;
    end
    if (state_q == ST_OUT && out_free) begin
      res_q           <= (code_q == CODE_W'(cand_q));
      computed_code_o <= code_q[19:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> state_q == ST_RUN) else $error("digest done outside run");

  a_mod_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_MOD) else $error("remainder done outside mod");

  a_start_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.start |=> state_q == ST_RUN) else $error("compression started out of load");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> out_valid_o) else $error("result dropped");

endmodule

`default_nettype wire

// File: tb/tb_hotp_code_check.sv
// ----------------------------------------------------------------------------
// tb_hotp_code_check
// Self-checking bench for the HOTP code checker: HMAC-SHA-1 of the counter
// under a configurable key, dynamic truncation, reduce modulo one million.
// Zero-key requests, a directed table, then random requests under several keys.
// ----------------------------------------------------------------------------
module tb_hotp_code_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MODULUS = 1000000;

  typedef struct {
    logic [63:0] ctr;
    logic [19:0] cand;
    logic        chk;
    logic        exp_ok;
    logic [19:0] exp_code;
  } vec_t;

  typedef struct {
    logic        ok;
    logic [19:0] code;
  } hotp_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] counter_i = '0;
  logic [19:0] candidate_code_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [19:0] computed_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [63:0] key_lo, key_mid;
  logic [31:0] key_hi;
  hotp_res_t   pending_codes[$];
  vec_t        dir_tab[$];
  int          n_err = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  hotp_code_check uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("timeout after %0d requests", n_req);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void compress(ref logic [31:0] h[5], input logic [31:0] blk[16]);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = hcc_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = hcc_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = hcc_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = hcc_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  function automatic hotp_res_t hotp_code(logic [63:0] ctr, logic [19:0] cand);
    logic [159:0] key;
    logic [159:0] mac;
    logic [31:0]  h[5];
    logic [31:0]  blk[16];
    logic [7:0]   mb[20];
    logic [31:0]  bin;
    int unsigned  off;
    hotp_res_t    r;
    key = {key_lo, key_mid, key_hi};
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    for (int i = 0; i < 16; i++) blk[i] = (i < 5 ? key[159 - 32*i -: 32] : 32'h0) ^ 32'h36363636;
    compress(h, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    blk[0] = ctr[63:32]; blk[1] = ctr[31:0]; blk[2] = 32'h80000000; blk[15] = 32'd576;
    compress(h, blk);
    mac = {h[0], h[1], h[2], h[3], h[4]};
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    for (int i = 0; i < 16; i++) blk[i] = (i < 5 ? key[159 - 32*i -: 32] : 32'h0) ^ 32'h5c5c5c5c;
    compress(h, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 5; i++) blk[i] = mac[159 - 32*i -: 32];
    blk[5] = 32'h80000000; blk[15] = 32'd672;
    compress(h, blk);
    for (int i = 0; i < 20; i++) mb[i] = h[i/4][31 - 8*(i%4) -: 8];
    off = mb[19] & 8'hF;
    bin = {1'b0, mb[off][6:0], mb[off+1], mb[off+2], mb[off+3]};
    bin = bin % MODULUS;
    r.ok = (bin == {12'h0, cand});
    r.code = bin[19:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_err++;
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hcc_pkg::CFG_KEY_LOW:  key_lo = data;
      hcc_pkg::CFG_KEY_MID:  key_mid = data;
      hcc_pkg::CFG_KEY_HIGH: key_hi = data[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (450) @(posedge clk_i);
  endtask

  task automatic set_key(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    drain();
    write_reg(hcc_pkg::CFG_KEY_LOW, lo);
    write_reg(hcc_pkg::CFG_KEY_MID, mid);
    write_reg(hcc_pkg::CFG_KEY_HIGH, hi);
    write_reg(2'd3, {$urandom, $urandom});
  endtask

  task automatic send(logic [63:0] ctr, logic [19:0] cand, logic chk, logic ok,
                      logic [19:0] code);
    hotp_res_t r;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1; counter_i = ctr; candidate_code_i = cand;
    do @(posedge clk_i); while (in_stall_o);
    r = hotp_code(ctr, cand);
    if (chk && (r.ok !== ok || r.code !== code)) begin
      r.ok = ok; r.code = code;
    end
    pending_codes.push_back(r);
    n_req++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!calm && !out_stall_i && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    hotp_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_res++;
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected result", computed_code_o, 0);
      end else begin
        w = pending_codes.pop_front();
        if (valid_res_o !== w.ok) report_mismatch("valid_res", valid_res_o, w.ok);
        if (computed_code_o !== w.code) report_mismatch("computed_code", computed_code_o, w.code);
      end
    end
  end

  initial begin
    vec_t        v;
    hotp_res_t   r;
    logic [63:0] c;
    key_lo = '0; key_mid = '0; key_hi = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // RFC 4226 key "12345678901234567890": codes for counters 0..9, wrong candidates, edge counters
    dir_tab.push_back('{64'd0, 20'd755224, 1'b1, 1'b1, 20'd755224});
    dir_tab.push_back('{64'd1, 20'd287082, 1'b1, 1'b1, 20'd287082});
    dir_tab.push_back('{64'd2, 20'd359152, 1'b1, 1'b1, 20'd359152});
    dir_tab.push_back('{64'd3, 20'd969429, 1'b1, 1'b1, 20'd969429});
    dir_tab.push_back('{64'd4, 20'd338314, 1'b1, 1'b1, 20'd338314});
    dir_tab.push_back('{64'd5, 20'd254676, 1'b1, 1'b1, 20'd254676});
    dir_tab.push_back('{64'd6, 20'd287922, 1'b1, 1'b1, 20'd287922});
    dir_tab.push_back('{64'd7, 20'd162583, 1'b1, 1'b1, 20'd162583});
    dir_tab.push_back('{64'd8, 20'd399871, 1'b1, 1'b1, 20'd399871});
    dir_tab.push_back('{64'd9, 20'd520489, 1'b1, 1'b1, 20'd520489});
    dir_tab.push_back('{64'd0, 20'd755225, 1'b1, 1'b0, 20'd755224});
    dir_tab.push_back('{64'd1, 20'hFFFFF, 1'b1, 1'b0, 20'd287082});
    dir_tab.push_back('{64'd2, 20'd1000000, 1'b1, 1'b0, 20'd359152});
    dir_tab.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 20'd0, 1'b0, 1'b0, 20'd0});
    dir_tab.push_back('{64'h8000_0000_0000_0000, 20'd999999, 1'b0, 1'b0, 20'd0});
    dir_tab.push_back('{64'h0000_0000_FFFF_FFFF, 20'hAAAAA, 1'b0, 1'b0, 20'd0});
    dir_tab.push_back('{64'hFFFF_FFFF_0000_0000, 20'h55555, 1'b0, 1'b0, 20'd0});

    // zero key after reset, then the RFC key with junk in the upper high bits
    send(64'd0, 20'd0, 1'b0, 1'b0, 20'd0);
    send(64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 1'b0, 1'b0, 20'd0);
    set_key(64'h3132333435363738, 64'h3930313233343536, 64'hDEADBEEF_37383930);
    foreach (dir_tab[i]) begin
      v = dir_tab[i];
      send(v.ctr, v.cand, v.chk, v.exp_ok, v.exp_code);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_key('1, '1, '1);
        1: set_key('0, '0, '0);
        2: set_key(64'h3132333435363738, 64'h3930313233343536, 64'h37383930);
        default: set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 172; i++) begin
        c = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) c = {$urandom_range(0, 3) == 0 ? 32'h0 : 32'hFFFF_FFFF, $urandom};
        r = hotp_code(c, 20'd0);
        case ($urandom_range(0, 3))
          0: send(c, r.code, 1'b0, 1'b0, 20'd0);
          1: send(c, 20'($urandom_range(1000000, 1048575)), 1'b0, 1'b0, 20'd0);
          default: send(c, 20'($urandom), 1'b0, 1'b0, 20'd0);
        endcase
      end
    end

    drain();
    $display("%0d requests, %0d results, keys: zero, all ones, RFC vector, random",
             n_req, n_res);
    if (n_err == 0 && pending_codes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/hcc_pkg.sv
rtl/hcc_ram.sv
rtl/hcc_sha1_core.sv
rtl/hcc_mod.sv
rtl/hotp_code_check.sv
tb/tb_hotp_code_check.sv
